// File: rtl/dq_pkg.sv
// shared types, codes and default sizes for the double-ended queue
package dq_pkg;

    // default sizes
    localparam int DQ_CAPACITY   = 64;
    localparam int DQ_DATA_WIDTH = 32;

    // fixed field widths of the request and response channels
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int READ_W   = 32;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 7;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_HEAD_PUSH  = 3'd0,
        KIND_TAIL_PUSH  = 3'd1,
        KIND_HEAD_POP   = 3'd2,
        KIND_TAIL_POP   = 3'd3,
        KIND_HEAD_INDEX = 3'd4,
        KIND_TAIL_INDEX = 3'd5,
        KIND_REMOVE     = 3'd6
    } kind_t;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_RANGE     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_READ  = 3'd1,
        S_SCAN  = 3'd2,
        S_SHIFT = 3'd3,
        S_RESP  = 3'd4
    } state_t;

    // one response item
    typedef struct packed {
        logic [READ_W-1:0] read_data;
        status_t           status;
        logic [LEN_W-1:0]  length;
    } result_t;

endpackage

// File: rtl/dq_if.sv
// request and response channel interfaces of the double-ended queue
interface dq_req_if
    import dq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;

    modport source (output valid, output kind, output value, output position, input ready);
    modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface dq_rsp_if
    import dq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [READ_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    length;

    modport source (output valid, output read_data, output status, output length, input ready);
    modport sink   (input valid, input read_data, input status, input length, output ready);
endinterface

// File: rtl/dq_mem.sv
// element store: one write port, one read port with registered read data
module dq_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/dq_ctrl.sv
// request sequencer: head pointer, element count, scan and shift over the store
module dq_ctrl
    import dq_pkg::*;
#(
    parameter int CAPACITY   = DQ_CAPACITY,
    parameter int DATA_WIDTH = DQ_DATA_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    dq_req_if.sink                      req,
    output logic                        res_valid,
    input  logic                        res_ready,
    output result_t                     res,
    output logic                        mem_wr_en,
    output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
    output logic [DATA_WIDTH-1:0]       mem_wr_data,
    output logic                        mem_rd_en,
    output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
    input  logic [DATA_WIDTH-1:0]       mem_rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    state_t                state_reg, state_next;
    logic [AW-1:0]         front_reg, front_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;
    kind_t                 kind_reg, kind_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [DATA_WIDTH-1:0] found_reg, found_next;
    result_t               pend_reg, pend_next;

    logic                  accept;
    kind_t                 kind_in;
    logic [DATA_WIDTH-1:0] val_in;
    logic [CW-1:0]         wr_off, rd_off;
    logic [CW-1:0]         idx_inc, idx_inc2;
    logic                  fin;
    result_t               fin_res;

    // physical slot of the element at a given offset from the head
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(CAPACITY))
        begin
            sum = sum - SW'(CAPACITY);
        end
        return AW'(sum);
    endfunction

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign kind_in   = kind_t'(req.kind);
    assign val_in    = DATA_WIDTH'(req.value);
    assign idx_inc   = idx_reg + CW'(1);
    assign idx_inc2  = idx_reg + CW'(2);

    assign mem_wr_addr = slot_of(front_reg, wr_off);
    assign mem_rd_addr = slot_of(front_reg, rd_off);

    // next state, memory accesses and result
    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        kind_next   = kind_reg;
        val_next    = val_reg;
        found_next  = found_reg;
        pend_next   = pend_reg;
        mem_wr_en   = 1'b0;
        mem_wr_data = mem_rd_data;
        wr_off      = idx_reg;
        mem_rd_en   = 1'b0;
        rd_off      = '0;
        fin         = 1'b0;
        fin_res     = '{read_data: '0, status: ST_OK, length: LEN_W'(count_reg)};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next = kind_in;
                    val_next  = val_in;
                    case (kind_in)
                        KIND_HEAD_PUSH, KIND_TAIL_PUSH:
                        begin
                            fin = 1'b1;
                            if (count_reg == CAP_C)
                            begin
                                fin_res.status = ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_data = val_in;
                                if (kind_in == KIND_HEAD_PUSH)
                                begin
                                    wr_off     = CAP_C - CW'(1);
                                    front_next = slot_of(front_reg, CAP_C - CW'(1));
                                end
                                else
                                begin
                                    wr_off = count_reg;
                                end
                                count_next     = count_reg + CW'(1);
                                fin_res.length = LEN_W'(count_reg + CW'(1));
                            end
                        end
                        KIND_HEAD_POP, KIND_TAIL_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                fin            = 1'b1;
                                fin_res.status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                rd_off     = (kind_in == KIND_HEAD_POP) ? '0
                                                                        : count_reg - CW'(1);
                                state_next = S_READ;
                            end
                        end
                        KIND_HEAD_INDEX, KIND_TAIL_INDEX:
                        begin
                            if (PW'(req.position) >= PW'(count_reg))
                            begin
                                fin            = 1'b1;
                                fin_res.status = ST_RANGE;
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                rd_off     = (kind_in == KIND_HEAD_INDEX)
                                           ? CW'(req.position)
                                           : count_reg - CW'(1) - CW'(req.position);
                                state_next = S_READ;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                fin            = 1'b1;
                                fin_res.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                rd_off     = '0;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            // read data of a pop or an index read is back
            S_READ:
            begin
                fin               = 1'b1;
                fin_res.read_data = READ_W'(mem_rd_data);
                case (kind_reg)
                    KIND_HEAD_POP:
                    begin
                        front_next     = slot_of(front_reg, CW'(1));
                        count_next     = count_reg - CW'(1);
                        fin_res.length = LEN_W'(count_reg - CW'(1));
                    end
                    KIND_TAIL_POP:
                    begin
                        count_next     = count_reg - CW'(1);
                        fin_res.length = LEN_W'(count_reg - CW'(1));
                    end
                    default:
                    begin
                    end
                endcase
            end

            // compare one element per cycle while the next one is read
            S_SCAN:
            begin
                if (mem_rd_data == val_reg)
                begin
                    found_next = mem_rd_data;
                    if (idx_inc == count_reg)
                    begin
                        fin               = 1'b1;
                        fin_res.read_data = READ_W'(mem_rd_data);
                        count_next        = count_reg - CW'(1);
                        fin_res.length    = LEN_W'(count_reg - CW'(1));
                    end
                    else
                    begin
                        mem_rd_en  = 1'b1;
                        rd_off     = idx_inc;
                        state_next = S_SHIFT;
                    end
                end
                else if (idx_inc == count_reg)
                begin
                    fin            = 1'b1;
                    fin_res.status = ST_NOT_FOUND;
                end
                else
                begin
                    mem_rd_en = 1'b1;
                    rd_off    = idx_inc;
                    idx_next  = idx_inc;
                end
            end

            // move element j+1 into slot j, reading j+2 meanwhile
            S_SHIFT:
            begin
                mem_wr_en   = 1'b1;
                wr_off      = idx_reg;
                mem_wr_data = mem_rd_data;
                if (idx_inc2 == count_reg)
                begin
                    fin               = 1'b1;
                    fin_res.read_data = READ_W'(found_reg);
                    count_next        = count_reg - CW'(1);
                    fin_res.length    = LEN_W'(count_reg - CW'(1));
                end
                else
                begin
                    mem_rd_en = 1'b1;
                    rd_off    = idx_inc2;
                    idx_next  = idx_inc;
                end
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hand the result over, or hold it while the output is busy
        if (fin)
        begin
            if (res_ready)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                pend_next  = fin_res;
                state_next = S_RESP;
            end
        end
    end

    assign res_valid = fin || (state_reg == S_RESP);
    assign res       = fin ? fin_res : pend_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // request payload and held result
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        val_reg   <= val_next;
        found_reg <= found_next;
        pend_reg  <= pend_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("element count beyond capacity");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg <= AW'(CAPACITY - 1))
        else $error("head pointer outside the store");

    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("read and write to the same slot in one cycle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status != ST_OK)) |-> (res.read_data == '0))
        else $error("failed request returned nonzero data");

    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((kind_in == KIND_HEAD_PUSH) || (kind_in == KIND_TAIL_PUSH))
         && (count_reg != CAP_C)) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("accepted push did not grow the queue");
`endif

endmodule

// File: rtl/double_ended_queue.sv
// Bounded double-ended queue of CAPACITY words kept in a single-port-read,
// single-port-write synchronous store with a circular head pointer. One
// request is worked on at a time and each gives exactly one response.
// Pushes and refused requests finish in the cycle they are transferred in;
// pops and index reads finish after one store read; remove-by-value is
// bound by the store's single read port: the scan compares one element
// per cycle and the gap is closed one element per cycle. A response that
// cannot leave because the output register is still occupied is held
// until it is taken. Store words are DATA_WIDTH bits; the request value
// is cut to that width and returned data is zero-extended.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int CAPACITY   = DQ_CAPACITY,
    parameter int DATA_WIDTH = DQ_DATA_WIDTH
) (
    input  logic     clk,
    input  logic     rst_n,
    dq_req_if.sink   req,
    dq_rsp_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic                  res_valid;
    logic                  res_ready;
    result_t               res;
    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    logic [DATA_WIDTH-1:0] mem_rd_data;
    logic                  out_valid_reg;
    result_t               out_res_reg;

    dq_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    dq_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register takes a new result when empty or being drained
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    // response channel
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_res_reg.read_data;
    assign rsp.status    = out_res_reg.status;
    assign rsp.length    = out_res_reg.length;

endmodule
